// ===== hw/rtl/gpundo_pkg.sv =====
// ----------------------------------------------------------------------------
// gpundo_pkg
// Shared types, constants and helpers for the gradient predictor undo block.
// ----------------------------------------------------------------------------
`default_nettype none

package gpundo_pkg;

  // Default sizing of the line store and the component lanes.
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_LANES_DEF = 4;

  // Fixed field widths.
  localparam int NUM_LANES  = 4;
  localparam int BYTE_W     = 8;
  localparam int PIXEL_W    = NUM_LANES * BYTE_W;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 16;
  localparam int BPP_W      = 3;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // Reset values of the configuration registers.
  localparam logic [WIDTH_W-1:0]  RECT_WIDTH_RST  = WIDTH_W'(1);
  localparam logic [HEIGHT_W-1:0] RECT_HEIGHT_RST = HEIGHT_W'(1);
  localparam logic [BPP_W-1:0]    BPP_RST         = BPP_W'(3);

  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RECT_WIDTH      = 2'd0,
    REG_RECT_HEIGHT     = 2'd1,
    REG_BYTES_PER_PIXEL = 2'd2
  } cfg_reg_t;

  // Which neighbors form the prediction of a pixel.
  typedef enum logic [1:0] {
    PRED_ZERO  = 2'd0,
    PRED_ABOVE = 2'd1,
    PRED_LEFT  = 2'd2,
    PRED_GRAD  = 2'd3
  } pred_mode_t;

  // Per-pixel control from the raster scan to the reconstruction stage.
  typedef struct packed {
    pred_mode_t             mode;
    logic                   last;
    logic [NUM_LANES-1:0]   lane_en;
  } scan_info_t;

  // left + above - above_left, clamped to one byte.
  function automatic logic [BYTE_W-1:0] grad_pred(
    input logic [BYTE_W-1:0] left_b,
    input logic [BYTE_W-1:0] above_b,
    input logic [BYTE_W-1:0] above_left_b
  );
    logic [BYTE_W+1:0] sum;
    logic [BYTE_W-1:0] res;
    sum = {2'b00, left_b} + {2'b00, above_b} - {2'b00, above_left_b};
    if (sum[BYTE_W+1]) begin
      res = '0;
    end else if (sum[BYTE_W]) begin
      res = BYTE_MAX;
    end else begin
      res = sum[BYTE_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gpundo_line_ram.sv =====
// ----------------------------------------------------------------------------
// gpundo_line_ram
// One-row line store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gpundo_line_ram #(
  parameter int DEPTH  = gpundo_pkg::MAX_WIDTH_DEF,
  parameter int ADDR_W = $clog2(gpundo_pkg::MAX_WIDTH_DEF),
  parameter int DATA_W = gpundo_pkg::PIXEL_W
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gpundo_scan.sv =====
// ----------------------------------------------------------------------------
// gpundo_scan
// Configuration registers and the raster column/row counters.
// ----------------------------------------------------------------------------
`default_nettype none

module gpundo_scan #(
  parameter int MAX_WIDTH = gpundo_pkg::MAX_WIDTH_DEF,
  parameter int MAX_LANES = gpundo_pkg::MAX_LANES_DEF,
  parameter int COL_W     = $clog2(gpundo_pkg::MAX_WIDTH_DEF)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [gpundo_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [gpundo_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                              accept,
  output logic      [COL_W-1:0]                  col,
  output gpundo_pkg::scan_info_t                 info
);

  localparam int CW = (COL_W + 1 > gpundo_pkg::WIDTH_W) ? COL_W + 1 : gpundo_pkg::WIDTH_W;
  localparam int RW = gpundo_pkg::HEIGHT_W + 1;

  logic [gpundo_pkg::WIDTH_W-1:0]  rect_width;
  logic [gpundo_pkg::HEIGHT_W-1:0] rect_height;
  logic [gpundo_pkg::BPP_W-1:0]    bytes_per_pixel;
  logic [gpundo_pkg::HEIGHT_W-1:0] row;
  logic [COL_W-1:0]                col_next;
  logic [gpundo_pkg::HEIGHT_W-1:0] row_next;
  logic [CW-1:0]                   col_inc;
  logic [RW-1:0]                   row_inc;
  logic                            row_end;
  logic                            rect_end;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_width      <= gpundo_pkg::RECT_WIDTH_RST;
      rect_height     <= gpundo_pkg::RECT_HEIGHT_RST;
      bytes_per_pixel <= gpundo_pkg::BPP_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        gpundo_pkg::REG_RECT_WIDTH: begin
          rect_width <= cfg_wdata[gpundo_pkg::WIDTH_W-1:0];
        end
        gpundo_pkg::REG_RECT_HEIGHT: begin
          rect_height <= cfg_wdata[gpundo_pkg::HEIGHT_W-1:0];
        end
        gpundo_pkg::REG_BYTES_PER_PIXEL: begin
          bytes_per_pixel <= cfg_wdata[gpundo_pkg::BPP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // End of row and rectangle; a zero width or height acts as one, and the
  // width saturates at the line store depth.
  always_comb begin
    col_inc  = CW'(col) + CW'(1);
    row_inc  = RW'(row) + RW'(1);
    row_end  = (col_inc >= CW'(rect_width)) || (col_inc >= CW'(MAX_WIDTH));
    rect_end = row_end && (row_inc >= RW'(rect_height));
    if (row_end) begin
      col_next = '0;
      row_next = rect_end ? '0 : row_inc[gpundo_pkg::HEIGHT_W-1:0];
    end else begin
      col_next = col_inc[COL_W-1:0];
      row_next = row;
    end
  end

  // Prediction mode, last flag and used lanes of the current pixel.
  always_comb begin
    if (row == '0 && col == '0) begin
      info.mode = gpundo_pkg::PRED_ZERO;
    end else if (col == '0) begin
      info.mode = gpundo_pkg::PRED_ABOVE;
    end else if (row == '0) begin
      info.mode = gpundo_pkg::PRED_LEFT;
    end else begin
      info.mode = gpundo_pkg::PRED_GRAD;
    end
    info.last = rect_end;
    for (int c = 0; c < gpundo_pkg::NUM_LANES; c++) begin
      info.lane_en[c] = (c == 0) ||
                        ((gpundo_pkg::BPP_W'(c) < bytes_per_pixel) && (c < MAX_LANES));
    end
  end

  // Raster counters advance on every accepted pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gpundo_recon.sv =====
// ----------------------------------------------------------------------------
// gpundo_recon
// Reconstruction stage: prediction from the line store word, left and
// above-left pixels, write-back to the line store and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gpundo_recon #(
  parameter int MAX_LANES = gpundo_pkg::MAX_LANES_DEF,
  parameter int COL_W     = $clog2(gpundo_pkg::MAX_WIDTH_DEF),
  parameter int WORD_W    = gpundo_pkg::MAX_LANES_DEF * gpundo_pkg::BYTE_W
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Request entering the stage.
  input  wire logic                           load,
  input  wire logic [COL_W-1:0]               load_col,
  input  wire gpundo_pkg::scan_info_t         load_info,
  input  wire logic [gpundo_pkg::PIXEL_W-1:0] load_res,
  output logic                                free,
  // Line store.
  input  wire logic [WORD_W-1:0]              rd_data,
  output logic                                wr_en,
  output logic      [COL_W-1:0]               wr_addr,
  output logic      [WORD_W-1:0]              wr_data,
  // Result stream.
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [gpundo_pkg::PIXEL_W-1:0] m_tdata,
  output logic                                m_tlast
);

  localparam int BW = gpundo_pkg::BYTE_W;

  logic                           s1_valid;
  logic [COL_W-1:0]               s1_col;
  gpundo_pkg::scan_info_t         s1_info;
  logic [gpundo_pkg::PIXEL_W-1:0] s1_res;
  logic                           byp_hit;
  logic [WORD_W-1:0]              byp_word;
  logic [WORD_W-1:0]              left_word;
  logic [WORD_W-1:0]              above_left_word;
  logic [WORD_W-1:0]              above_word;
  logic [gpundo_pkg::PIXEL_W-1:0] result;
  logic                           s1_adv;

  // Stage moves when the output register is empty or being drained.
  assign s1_adv = s1_valid && (!m_tvalid || m_tready);
  assign free   = !s1_valid || s1_adv;

  // The word read for this pixel misses a write made at the same edge.
  assign above_word = byp_hit ? byp_word : rd_data;

  // Per-lane prediction and reconstruction.
  for (genvar c = 0; c < gpundo_pkg::NUM_LANES; c++) begin : g_lane
    if (c < MAX_LANES) begin : g_used
      logic [BW-1:0] pred;
      always_comb begin
        case (s1_info.mode)
          gpundo_pkg::PRED_ZERO:  pred = '0;
          gpundo_pkg::PRED_ABOVE: pred = above_word[c*BW +: BW];
          gpundo_pkg::PRED_LEFT:  pred = left_word[c*BW +: BW];
          gpundo_pkg::PRED_GRAD: begin
            pred = gpundo_pkg::grad_pred(left_word[c*BW +: BW], above_word[c*BW +: BW],
                                         above_left_word[c*BW +: BW]);
          end
          default: pred = '0;
        endcase
      end
      assign result[c*BW +: BW] = s1_info.lane_en[c] ? (s1_res[c*BW +: BW] + pred) : '0;
    end else begin : g_unused
      assign result[c*BW +: BW] = '0;
    end
  end

  // Line store write-back.
  assign wr_en   = s1_adv;
  assign wr_addr = s1_col;
  assign wr_data = result[WORD_W-1:0];

  // Stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      byp_hit  <= 1'b0;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
        byp_hit  <= s1_adv && (s1_col == load_col);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (load) begin
      s1_col   <= load_col;
      s1_info  <= load_info;
      s1_res   <= load_res;
      byp_word <= result[WORD_W-1:0];
    end
  end

  // Neighbor pixels follow the reconstructed stream.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_word       <= '0;
      above_left_word <= '0;
    end else if (s1_adv) begin
      left_word       <= result[WORD_W-1:0];
      above_left_word <= above_word;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tdata <= result;
      m_tlast <= s1_info.last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gradient_predictor_undo_top.sv =====
// ----------------------------------------------------------------------------
// gradient_predictor_undo_top
// Undoes gradient prediction on a raster rectangle, one pixel per request.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_*       in         tdata: residual_0..residual_3 (bits 7:0 up to 31:24)
//  m_*       out        tdata: pixel_byte_0..pixel_byte_3; tlast: last_of_rect
//  cfg_*     in         cfg_addr selects rect_width, rect_height, bytes_per_pixel
//
// One pixel per cycle sustained unless the output stalls. A pixel is accepted,
// its line store word is read at the accept edge, and its result enters the
// output register once the output is free. The single line store port pair
// sets the rate: one read and one write per pixel. Reset clears the counters,
// neighbors and valid flags; the line store is not cleared. A stalled output
// holds one result and one more pixel in flight before s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_predictor_undo_top #(
  parameter int MAX_WIDTH = gpundo_pkg::MAX_WIDTH_DEF,
  parameter int MAX_LANES = gpundo_pkg::MAX_LANES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration writes.
  input  wire logic                              cfg_we,
  input  wire logic [gpundo_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [gpundo_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Residual stream.
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // residual_0, residual_1, residual_2, residual_3
  input  wire logic [gpundo_pkg::PIXEL_W-1:0]    s_tdata,
  // Pixel stream.
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // pixel_byte_0, pixel_byte_1, pixel_byte_2, pixel_byte_3
  output logic      [gpundo_pkg::PIXEL_W-1:0]    m_tdata,
  output logic                                   m_tlast
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WORD_W = MAX_LANES * gpundo_pkg::BYTE_W;

  logic                   accept;
  logic [COL_W-1:0]       col;
  gpundo_pkg::scan_info_t info;
  logic [WORD_W-1:0]      rd_data;
  logic                   wr_en;
  logic [COL_W-1:0]       wr_addr;
  logic [WORD_W-1:0]      wr_data;

  assign accept = s_tvalid && s_tready;

  gpundo_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_LANES (MAX_LANES),
    .COL_W     (COL_W)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .col       (col),
    .info      (info)
  );

  gpundo_line_ram #(
    .DEPTH   (MAX_WIDTH),
    .ADDR_W  (COL_W),
    .DATA_W  (WORD_W)
  ) u_line_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  gpundo_recon #(
    .MAX_LANES (MAX_LANES),
    .COL_W     (COL_W),
    .WORD_W    (WORD_W)
  ) u_recon (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .load_col  (col),
    .load_info (info),
    .load_res  (s_tdata),
    .free      (s_tready),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/gpundo_checker.sv =====
// ----------------------------------------------------------------------------
// gpundo_port_checker
// Port-level checks of the gradient predictor undo block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module gpundo_port_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [gpundo_pkg::PIXEL_W-1:0] m_tdata,
  input wire logic                           m_tlast
);

  // Nothing is presented right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // With a result stalled and one more pixel taken, the block is full.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    $past(m_tvalid && !m_tready && s_tvalid && s_tready) && !$past(rst)
      && m_tvalid && !m_tready |-> !s_tready)
    else $error("pixel accepted with no room");

  // With the output empty, a new pixel is always taken.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && !$past(s_tvalid && s_tready) |-> s_tready)
    else $error("input stalled with the pipeline empty");

endmodule

bind gradient_predictor_undo_top gpundo_port_checker u_port_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== verif/gpundo_checker.sv =====
// ----------------------------------------------------------------------------
// gpundo_checker
// Watches the configuration port and both pixel streams of the gradient
// predictor undo block. It keeps its own copy of the registers, the line
// store, the neighbor pixels and the raster counters. From these it rebuilds
// each accepted residual request into the pixel it must produce. Every pixel
// that leaves the block is compared lane by lane, and on its last flag, with
// the oldest pixel still awaited.
// ----------------------------------------------------------------------------
module gpundo_checker import gpundo_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  // residual_0, residual_1, residual_2, residual_3
  input  logic [PIXEL_W-1:0]    s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // pixel_byte_0, pixel_byte_1, pixel_byte_2, pixel_byte_3
  input  logic [PIXEL_W-1:0]    m_tdata,
  input  logic                  m_tlast,
  output int unsigned           mismatch_count,
  output int unsigned           pixels_in_flight,
  output int unsigned           pixels_checked,
  output int unsigned           rects_closed
);

  // One reconstructed pixel as it leaves the block.
  typedef struct packed {
    logic                             last;
    logic [NUM_LANES-1:0][BYTE_W-1:0] lane;
  } pixel_rec_t;

  localparam int unsigned PRINT_LIMIT = 30;

  // Shadow registers.
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [BPP_W-1:0]    lanes_reg;

  // Shadow of the block's working state.
  logic [PIXEL_W-1:0]  line_mem [MAX_WIDTH_DEF];
  logic [PIXEL_W-1:0]  left_word;
  logic [PIXEL_W-1:0]  above_left_word;
  int                  col_cnt;
  int                  row_cnt;

  // Pixels predicted but not yet seen on the output.
  pixel_rec_t          awaited_pixels [$];

  initial begin
    mismatch_count   = 0;
    pixels_in_flight = 0;
    pixels_checked   = 0;
    rects_closed     = 0;
  end

  // Print one line per mismatch, up to a limit, and count every one.
  task automatic flag_mismatch(input string what, input logic [PIXEL_W-1:0] got_v,
                               input logic [PIXEL_W-1:0] want_v);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s: got %h, expected %h", $time, what, got_v, want_v);
    end
    mismatch_count++;
  endtask

  // Undo the gradient prediction for one residual request and advance the scan.
  task automatic rebuild_pixel(input logic [PIXEL_W-1:0] resid, output pixel_rec_t px);
    int                 w;
    int                 h;
    int                 lanes;
    int                 col;
    int                 pred;
    logic [PIXEL_W-1:0] above;
    logic [BYTE_W-1:0]  lf;
    logic [BYTE_W-1:0]  ab;
    logic [BYTE_W-1:0]  al;
    bit                 top_row;
    bit                 left_col;
    bit                 row_done;
    // Out-of-range register values are pulled into the legal range.
    w = (width_reg == '0) ? 1 : int'(width_reg);
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    h = (height_reg == '0) ? 1 : int'(height_reg);
    lanes = (lanes_reg == '0) ? 1 : int'(lanes_reg);
    if (lanes > MAX_LANES_DEF) lanes = MAX_LANES_DEF;
    col = (col_cnt >= MAX_WIDTH_DEF) ? MAX_WIDTH_DEF - 1 : col_cnt;
    above = line_mem[col];
    top_row = (row_cnt == 0);
    left_col = (col == 0);
    px = '0;
    for (int c = 0; c < NUM_LANES; c++) begin
      if (c < lanes) begin
        lf = left_word[c*BYTE_W +: BYTE_W];
        ab = above[c*BYTE_W +: BYTE_W];
        al = above_left_word[c*BYTE_W +: BYTE_W];
        if (top_row && left_col) begin
          pred = 0;
        end else if (left_col) begin
          pred = int'(ab);
        end else if (top_row) begin
          pred = int'(lf);
        end else begin
          pred = int'(lf) + int'(ab) - int'(al);
          if (pred < 0) begin
            pred = 0;
          end else if (pred > int'(BYTE_MAX)) begin
            pred = int'(BYTE_MAX);
          end
        end
        px.lane[c] = resid[c*BYTE_W +: BYTE_W] + pred[BYTE_W-1:0];
      end
    end
    // Unused lanes go into the line store as zero.
    line_mem[col] = px.lane;
    left_word = px.lane;
    above_left_word = above;
    row_done = (col + 1 >= w);
    px.last = row_done && (row_cnt + 1 >= h);
    if (row_done) begin
      col_cnt = 0;
      row_cnt = px.last ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col + 1;
    end
  endtask

  // Sample all channels at each rising edge.
  always @(posedge clk) begin
    pixel_rec_t want;
    pixel_rec_t got;
    if (rst) begin
      width_reg = RECT_WIDTH_RST;
      height_reg = RECT_HEIGHT_RST;
      lanes_reg = BPP_RST;
      left_word = '0;
      above_left_word = '0;
      col_cnt = 0;
      row_cnt = 0;
      awaited_pixels.delete();
      pixels_in_flight <= 0;
    end else begin
      if ($isunknown(m_tvalid) || $isunknown(s_tready)) begin
        flag_mismatch("handshake signal unknown", PIXEL_W'({m_tvalid, s_tready}), '0);
      end
      // An output pixel can only belong to a request from an earlier edge.
      if (m_tvalid && m_tready) begin
        got.lane = m_tdata;
        got.last = m_tlast;
        pixels_checked++;
        if (m_tlast) rects_closed++;
        if (awaited_pixels.size() == 0) begin
          flag_mismatch("pixel out with none awaited", m_tdata, '0);
        end else begin
          want = awaited_pixels.pop_front();
          for (int c = 0; c < NUM_LANES; c++) begin
            if (got.lane[c] !== want.lane[c]) begin
              flag_mismatch($sformatf("pixel %0d byte %0d", pixels_checked, c),
                            PIXEL_W'(got.lane[c]), PIXEL_W'(want.lane[c]));
            end
          end
          if (got.last !== want.last) begin
            flag_mismatch($sformatf("pixel %0d last_of_rect", pixels_checked),
                          PIXEL_W'(got.last), PIXEL_W'(want.last));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        rebuild_pixel(s_tdata, want);
        awaited_pixels.push_back(want);
      end
      // Register writes take effect from the next request on.
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_RECT_WIDTH:      width_reg = cfg_wdata[WIDTH_W-1:0];
          REG_RECT_HEIGHT:     height_reg = cfg_wdata[HEIGHT_W-1:0];
          REG_BYTES_PER_PIXEL: lanes_reg = cfg_wdata[BPP_W-1:0];
          default: ;
        endcase
      end
      pixels_in_flight <= awaited_pixels.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the gradient predictor undo block. A short directed part hits
// the clamps, the first row and column, the out-of-range register values and
// register changes in the middle of a rectangle, among them a saturating width
// that a narrower one later cuts short. A random part follows: many small
// rectangles with random residuals and random register settings. Both streams
// pause at random. The checker beside the block predicts and compares; this
// module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import gpundo_pkg::*;

  localparam int unsigned RANDOM_PIXELS = 1200;
  localparam int unsigned RUN_LIMIT     = 9_600_000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // residual_0, residual_1, residual_2, residual_3
  logic [PIXEL_W-1:0]    s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // pixel_byte_0, pixel_byte_1, pixel_byte_2, pixel_byte_3
  logic [PIXEL_W-1:0]    m_tdata;
  logic                  m_tlast;

  int unsigned mismatch_count;
  int unsigned pixels_in_flight;
  int unsigned pixels_checked;
  int unsigned rects_closed;

  // Register values as written, and where the scan stands.
  logic [WIDTH_W-1:0]  width_set = RECT_WIDTH_RST;
  logic [HEIGHT_W-1:0] height_set = RECT_HEIGHT_RST;
  int                  col_pos = 0;
  int                  row_pos = 0;
  bit                  col_written [MAX_WIDTH_DEF];
  bit                  src_quiet = 1'b0;
  int unsigned         pixels_sent = 0;
  int unsigned         reg_writes = 0;
  int                  widest_row = 1;
  int                  deepest_row = 0;

  gradient_predictor_undo_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  gpundo_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast),
    .mismatch_count  (mismatch_count),
    .pixels_in_flight(pixels_in_flight),
    .pixels_checked  (pixels_checked),
    .rects_closed    (rects_closed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly no pause, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int eff_width(logic [WIDTH_W-1:0] raw);
    if (raw == '0) return 1;
    if (int'(raw) > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return int'(raw);
  endfunction

  function automatic int eff_height(logic [HEIGHT_W-1:0] raw);
    return (raw == '0) ? 1 : int'(raw);
  endfunction

  // Pixels still to go before the current rectangle closes.
  function automatic longint rect_left();
    longint w;
    longint h;
    longint n;
    w = eff_width(width_set);
    h = eff_height(height_set);
    n = (col_pos >= w) ? 1 : w - col_pos;
    if (row_pos + 1 < h) n += (h - row_pos - 1) * w;
    return n;
  endfunction

  // A new width mid-rectangle must not make the block read a line store word
  // that was never written.
  function automatic bit width_ok(logic [WIDTH_W-1:0] raw);
    int stop;
    if (row_pos == 0) return 1'b1;
    stop = eff_width(raw) - 1;
    if (stop < col_pos) stop = col_pos;
    for (int c = col_pos; c <= stop; c++) begin
      if (!col_written[c]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Residuals: mostly random, sometimes all-zero, all-ones or edge bytes.
  function automatic logic [PIXEL_W-1:0] rand_pixel();
    logic [PIXEL_W-1:0] d;
    int                 r;
    r = $urandom_range(0, 9);
    d = $urandom;
    if (r == 0) begin
      d = '0;
    end else if (r == 1) begin
      d = '1;
    end else if (r == 2) begin
      for (int c = 0; c < NUM_LANES; c++) begin
        case ($urandom_range(0, 3))
          0: d[c*BYTE_W +: BYTE_W] = 8'h00;
          1: d[c*BYTE_W +: BYTE_W] = 8'hFF;
          2: d[c*BYTE_W +: BYTE_W] = 8'h01;
          default: d[c*BYTE_W +: BYTE_W] = 8'h80;
        endcase
      end
    end
    return d;
  endfunction

  function automatic int pick_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 88) return $urandom_range(9, 40);
    if (r < 93) return 0;
    return $urandom_range(41, 300);
  endfunction

  function automatic int pick_height();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 6);
    if (r < 88) return $urandom_range(7, 20);
    if (r < 94) return 0;
    return 65535;
  endfunction

  // Offer one residual request and wait for it to be taken.
  task automatic send_pixel(input logic [PIXEL_W-1:0] d);
    int gap;
    gap = src_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // Track the scan position the same way the block advances it.
    col_written[col_pos] = 1'b1;
    pixels_sent++;
    if (col_pos + 1 >= eff_width(width_set)) begin
      if (col_pos + 1 > widest_row) widest_row = col_pos + 1;
      col_pos = 0;
      row_pos = (row_pos + 1 >= eff_height(height_set)) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    if (row_pos > deepest_row) deepest_row = row_pos;
  endtask

  task automatic finish_rect();
    while (col_pos != 0 || row_pos != 0) send_pixel(rand_pixel());
  endtask

  // Stop sending and wait until every pixel has come out and the pipe is empty.
  task automatic go_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pixels_in_flight != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Register write; unused upper data bits carry random values.
  task automatic write_reg(input cfg_reg_t idx, input int unsigned v);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    case (idx)
      REG_RECT_WIDTH: begin
        d[WIDTH_W-1:0] = v[WIDTH_W-1:0];
        width_set = v[WIDTH_W-1:0];
      end
      REG_RECT_HEIGHT: begin
        d = v[HEIGHT_W-1:0];
        height_set = v[HEIGHT_W-1:0];
      end
      REG_BYTES_PER_PIXEL: d[BPP_W-1:0] = v[BPP_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  // Output back-pressure: calm stretches alternate with random stalls.
  int stall_left = 0;
  int calm_left = 0;
  bit calm = 1'b0;
  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm = ($urandom_range(0, 2) == 0);
      calm_left = $urandom_range(50, 300);
    end else begin
      calm_left--;
    end
    if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    int unsigned rand_base;
    int          v;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: single-pixel rectangles, top lane ignored.
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);

    // 3x2 rectangle with all lanes: clamps at both ends of the gradient.
    go_idle();
    write_reg(REG_RECT_WIDTH, 3);
    write_reg(REG_RECT_HEIGHT, 2);
    write_reg(REG_BYTES_PER_PIXEL, 4);
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0101_0101);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h8080_8080);
    send_pixel(32'h55AA_55AA);

    // Zero width, height and lane count act as one.
    go_idle();
    write_reg(REG_RECT_WIDTH, 0);
    write_reg(REG_RECT_HEIGHT, 0);
    write_reg(REG_BYTES_PER_PIXEL, 0);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h1234_5678);

    // Too many lanes saturate; the height is cut short mid-rectangle.
    go_idle();
    write_reg(REG_BYTES_PER_PIXEL, 7);
    write_reg(REG_RECT_WIDTH, 2);
    write_reg(REG_RECT_HEIGHT, 65535);
    repeat (5) send_pixel(rand_pixel());
    go_idle();
    write_reg(REG_RECT_HEIGHT, 2);
    finish_rect();

    // The width shrinks below the current column mid-rectangle.
    go_idle();
    write_reg(REG_RECT_WIDTH, 3);
    write_reg(REG_RECT_HEIGHT, 3);
    write_reg(REG_BYTES_PER_PIXEL, 2);
    repeat (4) send_pixel(rand_pixel());
    go_idle();
    write_reg(REG_RECT_WIDTH, 1);
    finish_rect();

    // A saturating width opens a long first row; a narrower width closes it.
    go_idle();
    write_reg(REG_RECT_WIDTH, 4095);
    write_reg(REG_RECT_HEIGHT, 1);
    write_reg(REG_BYTES_PER_PIXEL, 4);
    repeat (60) send_pixel(rand_pixel());
    go_idle();
    write_reg(REG_RECT_WIDTH, 80);
    finish_rect();

    // Random phases: new settings between phases, some in mid-rectangle.
    rand_base = pixels_sent;
    while (pixels_sent - rand_base < RANDOM_PIXELS) begin
      go_idle();
      src_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 1) == 1) begin
          v = pick_width();
          if (width_ok(v[WIDTH_W-1:0])) write_reg(REG_RECT_WIDTH, v);
        end
        if ($urandom_range(0, 1) == 1) write_reg(REG_RECT_HEIGHT, pick_height());
        if ($urandom_range(0, 1) == 1) write_reg(REG_BYTES_PER_PIXEL, $urandom_range(0, 7));
      end
      if (rect_left() <= 200 && $urandom_range(0, 3) != 0) begin
        finish_rect();
        repeat ($urandom_range(0, 2)) begin
          if (rect_left() <= 60) begin
            send_pixel(rand_pixel());
            finish_rect();
          end
        end
      end else begin
        repeat ($urandom_range(1, 24)) send_pixel(rand_pixel());
      end
    end

    // Drain, then allow the pipeline latency to run out.
    s_tvalid <= 1'b0;
    for (int n = 0; n < 20000 && pixels_in_flight != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Summary: %0d pixels sent, %0d checked, %0d rectangles closed, %0d reg writes.",
             pixels_sent, pixels_checked, rects_closed, reg_writes);
    $display("Summary: rows up to %0d pixels wide, scan reached row %0d.",
             widest_row, deepest_row);
    if (pixels_in_flight != 0) begin
      $display("%0d pixels never came out", pixels_in_flight);
    end
    if (mismatch_count == 0 && pixels_in_flight == 0) begin
      $display("PASS gradient_predictor_undo_top");
    end else begin
      $display("FAIL gradient_predictor_undo_top");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(RUN_LIMIT);
    $display("FAIL gradient_predictor_undo_top");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/gpundo_pkg.sv
hw/rtl/gpundo_line_ram.sv
hw/rtl/gpundo_scan.sv
hw/rtl/gpundo_recon.sv
hw/rtl/gradient_predictor_undo_top.sv
hw/rtl/gpundo_checker.sv
verif/gpundo_checker.sv
verif/tb_top.sv
